// ----- hw/rtl/cpq_pkg.sv -----
// Package: shared widths, action codes, engine status codes and command struct.
`default_nettype none

package cpq_pkg;

   localparam int CLIP_W  = 16;
   localparam int STAT_W  = 4;
   localparam int CUR_W   = 17;
   localparam int TICK_W  = 18;
   localparam int LIMIT_W = 16;
   localparam int ACT_W   = 3;

   localparam int QUEUE_DEPTH_DEFAULT = 6;
   localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 16'd5400;

   localparam logic signed [STAT_W-1:0] STATUS_IDLE    = -4'sd1;
   localparam logic signed [STAT_W-1:0] STATUS_PLAYING = 4'sd2;

   typedef enum logic [ACT_W-1:0] {
      ACT_TICK    = 3'd0,
      ACT_ENQUEUE = 3'd1,
      ACT_SCHED   = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_ACK     = 3'd4
   } act_type;

   typedef enum logic {
      CTL_EMPTY,
      CTL_HOLD
   } ctl_state_type;

   typedef struct packed {
      logic step;
      logic do_tick;
      logic do_enq;
      logic do_sched;
      logic do_clear;
      logic do_ack;
      logic cfg_write;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/cpq_ctrl.sv -----
// Controller: request handshake, action decode and result hold state machine.
`default_nettype none

module cpq_ctrl
   import cpq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ACT_W-1:0] req_action,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   output cmd_type               cmd
);

   ctl_state_type state_ff, state_in;
   logic          accept;

   // hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // advance on accept, drop the result once taken
   always_comb begin
      req_stall = (state_ff == CTL_HOLD) && rsp_stall;
      rsp_valid = (state_ff == CTL_HOLD);
      accept    = req_valid && !req_stall;
      state_in  = state_ff;
      unique case (state_ff)
         CTL_EMPTY: begin
            if (accept) state_in = CTL_HOLD;
         end
         CTL_HOLD: begin
            if (!accept && !rsp_stall) state_in = CTL_EMPTY;
         end
         default: state_in = CTL_EMPTY;
      endcase
   end

   // decode the action of an accepted request
   always_comb begin
      cmd           = '0;
      cmd.step      = accept;
      cmd.cfg_write = csr_valid && csr_ready;
      unique case (req_action)
         ACT_TICK:    cmd.do_tick  = accept;
         ACT_ENQUEUE: cmd.do_enq   = accept;
         ACT_SCHED:   cmd.do_sched = accept;
         ACT_CLEAR:   cmd.do_clear = accept;
         ACT_ACK:     cmd.do_ack   = accept;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cpq_datapath.sv -----
// Datapath: clip queue, tick counters, pending enqueue and result registers.
`default_nettype none

module cpq_datapath
   import cpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic [CLIP_W-1:0]        req_clip_id,
   input  wire logic [CLIP_W-1:0]        req_delay_ticks,
   input  wire logic signed [STAT_W-1:0] req_engine_status,
   input  wire logic [LIMIT_W-1:0]       csr_timeout_limit,
   output logic                          rsp_start_request,
   output logic [CLIP_W-1:0]             rsp_start_clip,
   output logic                          rsp_stop_request,
   output logic signed [CUR_W-1:0]       rsp_current_clip,
   output logic                          rsp_finished_pulse,
   output logic                          rsp_started_pulse,
   output logic                          rsp_is_playing,
   output logic                          rsp_first_play_match,
   output logic                          rsp_finished_match,
   output logic                          rsp_enqueue_ok,
   output logic signed [STAT_W-1:0]      rsp_last_status
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // architectural state
   logic [CLIP_W-1:0]        queue_ff [QUEUE_DEPTH];
   logic [CLIP_W-1:0]        queue_in [QUEUE_DEPTH];
   logic [CLIP_W-1:0]        q_push   [QUEUE_DEPTH];
   logic [CLIP_W-1:0]        q_shift  [QUEUE_DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [STAT_W-1:0] prev_ff, prev_in;
   logic signed [CUR_W-1:0]  playing_ff, playing_in;
   logic signed [CUR_W-1:0]  retired_ff, retired_in;
   logic                     rflag_ff, rflag_in;
   logic                     sflag_ff, sflag_in;
   logic signed [TICK_W-1:0] play_ff, play_in;
   logic signed [TICK_W-1:0] elap_ff, elap_in;
   logic [CLIP_W-1:0]        pclip_ff, pclip_in;
   logic [CLIP_W-1:0]        pdelay_ff, pdelay_in;
   logic [LIMIT_W-1:0]       limit_ff;

   // per-request working values
   logic                     push_req, push_ok, counting, timeout, retire, start;
   logic [CLIP_W-1:0]        push_data, head;
   logic [CNT_W-1:0]         count_push, count_ret;
   logic signed [TICK_W-1:0] play_inc, elap_inc;
   logic                     start_req, stop_req, fin_match, enq_ok;
   logic [CLIP_W-1:0]        start_clip;

   // compute next state and result of one request
   always_comb begin
      queue_in   = queue_ff;
      count_in   = count_ff;
      prev_in    = prev_ff;
      playing_in = playing_ff;
      retired_in = retired_ff;
      rflag_in   = rflag_ff;
      sflag_in   = sflag_ff;
      play_in    = play_ff;
      elap_in    = elap_ff;
      pclip_in   = pclip_ff;
      pdelay_in  = pdelay_ff;
      start_req  = 1'b0;
      start_clip = '0;
      stop_req   = 1'b0;
      fin_match  = 1'b0;
      enq_ok     = 1'b0;

      // push path shared by enqueue and the expiring delayed enqueue
      push_req  = cmd.do_enq || (cmd.do_tick && (pdelay_ff == CLIP_W'(1)));
      push_data = cmd.do_tick ? pclip_ff : req_clip_id;
      push_ok   = push_req && (count_ff != CNT_W'(QUEUE_DEPTH));
      count_push = count_ff + CNT_W'(push_ok);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_push[i] = (push_ok && (count_ff == CNT_W'(i))) ? push_data : queue_ff[i];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         q_shift[i] = q_push[i + 1];
      end
      q_shift[QUEUE_DEPTH - 1] = q_push[QUEUE_DEPTH - 1];

      // tick counters and retire decision
      counting = !play_ff[TICK_W-1] && (count_push != '0) && (prev_ff != STATUS_IDLE);
      play_inc = play_ff + TICK_W'(prev_ff == STATUS_PLAYING);
      elap_inc = elap_ff + TICK_W'(1);
      timeout  = counting && (elap_inc > $signed({2'b00, limit_ff}));
      retire   = counting && ((req_engine_status == STATUS_IDLE) || timeout);
      count_ret = count_push - CNT_W'(retire);
      start    = (req_engine_status == STATUS_IDLE) && (count_ret != '0);
      head     = retire ? q_shift[0] : q_push[0];

      if (cmd.do_tick) begin
         if (pdelay_ff != '0) pdelay_in = pdelay_ff - CLIP_W'(1);
         queue_in = retire ? q_shift : q_push;
         count_in = count_ret;
         prev_in  = req_engine_status;
         rflag_in = retire;
         sflag_in = start;
         stop_req = timeout;
         if (counting) begin
            play_in = play_inc;
            elap_in = elap_inc;
         end
         if (retire) begin
            playing_in = -17'sd1;
            retired_in = $signed({1'b0, q_push[0]});
            play_in    = -18'sd1;
            elap_in    = -18'sd1;
         end
         if (start) begin
            play_in    = '0;
            elap_in    = '0;
            playing_in = $signed({1'b0, head});
            start_req  = 1'b1;
            start_clip = head;
         end
      end else if (cmd.do_enq) begin
         queue_in = q_push;
         count_in = count_push;
         enq_ok   = push_ok;
      end else if (cmd.do_sched) begin
         pclip_in  = req_clip_id;
         pdelay_in = req_delay_ticks;
      end else if (cmd.do_clear) begin
         count_in   = '0;
         prev_in    = STATUS_IDLE;
         playing_in = -17'sd1;
         retired_in = -17'sd1;
         rflag_in   = 1'b0;
         sflag_in   = 1'b0;
         play_in    = -18'sd1;
         elap_in    = -18'sd1;
         pclip_in   = '0;
         pdelay_in  = '0;
         stop_req   = (req_engine_status != STATUS_IDLE);
      end else if (cmd.do_ack) begin
         if (rflag_ff && (retired_ff == $signed({1'b0, req_clip_id}))) begin
            retired_in = -17'sd1;
            fin_match  = 1'b1;
         end
      end
   end

   // hold the control state, update on each accepted request; the timeout limit on a register write
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         prev_ff    <= '0;
         playing_ff <= -17'sd1;
         retired_ff <= -17'sd1;
         rflag_ff   <= 1'b0;
         sflag_ff   <= 1'b0;
         play_ff    <= '0;
         elap_ff    <= '0;
         pclip_ff   <= '0;
         pdelay_ff  <= '0;
         limit_ff   <= TIMEOUT_RESET;
      end else begin
         if (cmd.step) begin
            count_ff   <= count_in;
            prev_ff    <= prev_in;
            playing_ff <= playing_in;
            retired_ff <= retired_in;
            rflag_ff   <= rflag_in;
            sflag_ff   <= sflag_in;
            play_ff    <= play_in;
            elap_ff    <= elap_in;
            pclip_ff   <= pclip_in;
            pdelay_ff  <= pdelay_in;
         end
         if (cmd.cfg_write) limit_ff <= csr_timeout_limit;
      end
   end

   // queue entries and result registers carry no reset
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         queue_ff             <= queue_in;
         rsp_start_request    <= start_req;
         rsp_start_clip       <= start_clip;
         rsp_stop_request     <= stop_req;
         rsp_current_clip     <= playing_in;
         rsp_finished_pulse   <= rflag_in;
         rsp_started_pulse    <= sflag_in;
         rsp_is_playing       <= (play_in > 18'sd0);
         rsp_first_play_match <= (playing_in == $signed({1'b0, req_clip_id}))
                                 && (play_in == 18'sd1);
         rsp_finished_match   <= fin_match;
         rsp_enqueue_ok       <= enq_ok;
         rsp_last_status      <= prev_in;
      end
   end

   // fill count stays within the queue depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // play ticks never run ahead of elapsed ticks
   a_play_le_elap: assert property (@(posedge clock) disable iff (reset)
      play_ff <= elap_ff)
      else $error("play ticks exceed elapsed ticks");

   // a started clip is a real clip id
   a_start_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && cmd.do_tick && start) |=> !playing_ff[CUR_W-1])
      else $error("started clip left playing clip empty");

   // state holds while no request is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.step |=> ($stable(count_ff) && $stable(play_ff) && $stable(pdelay_ff)))
      else $error("state changed without a request");

endmodule

`default_nettype wire

// ----- hw/rtl/clip_playback_queue.sv -----
// Top level: clip playback queue with request, response and timeout register port.
`default_nettype none

// One request is taken per clock cycle; the result appears in the response
// register on the next cycle, and a new request is taken in the same cycle that
// the waiting response is taken, so the sustained rate is one request per
// cycle; each accepted request updates the queue, the tick counters and the
// pending enqueue. A held response stalls the request side.
// The timeout register resets to 5400 and may be written at any time the block
// is idle; csr_ready is always high.

module clip_playback_queue
   import cpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ACT_W-1:0]         req_action,
   input  wire logic [CLIP_W-1:0]        req_clip_id,
   input  wire logic [CLIP_W-1:0]        req_delay_ticks,
   input  wire logic signed [STAT_W-1:0] req_engine_status,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_start_request,
   output logic [CLIP_W-1:0]             rsp_start_clip,
   output logic                          rsp_stop_request,
   output logic signed [CUR_W-1:0]       rsp_current_clip,
   output logic                          rsp_finished_pulse,
   output logic                          rsp_started_pulse,
   output logic                          rsp_is_playing,
   output logic                          rsp_first_play_match,
   output logic                          rsp_finished_match,
   output logic                          rsp_enqueue_ok,
   output logic signed [STAT_W-1:0]      rsp_last_status,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [LIMIT_W-1:0]       csr_timeout_limit
);

   cmd_type cmd;

   // register writes are always taken
   assign csr_ready = 1'b1;

   cpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd)
   );

   cpq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_clip_id          (req_clip_id),
      .req_delay_ticks      (req_delay_ticks),
      .req_engine_status    (req_engine_status),
      .csr_timeout_limit    (csr_timeout_limit),
      .rsp_start_request    (rsp_start_request),
      .rsp_start_clip       (rsp_start_clip),
      .rsp_stop_request     (rsp_stop_request),
      .rsp_current_clip     (rsp_current_clip),
      .rsp_finished_pulse   (rsp_finished_pulse),
      .rsp_started_pulse    (rsp_started_pulse),
      .rsp_is_playing       (rsp_is_playing),
      .rsp_first_play_match (rsp_first_play_match),
      .rsp_finished_match   (rsp_finished_match),
      .rsp_enqueue_ok       (rsp_enqueue_ok),
      .rsp_last_status      (rsp_last_status)
   );

endmodule

`default_nettype wire
